[rtl/line_break_joiner_core_macros.svh]
// Assertion macros shared by the line break joiner RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef LINE_BREAK_JOINER_CORE_MACROS_SVH
`define LINE_BREAK_JOINER_CORE_MACROS_SVH

// Same-cycle implication.
`define LBJ_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LBJ_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lbj_pkg.sv]
// Shared types and constants of the line break joiner.
// No dependencies; imported by every RTL file.
`default_nettype none

package lbj_pkg;

  localparam int unsigned CHAR_W = 16;
  localparam int unsigned HELD_W = 6;

  localparam logic [HELD_W-1:0] MAX_HELD_HYPHENS = HELD_W'(63);

  localparam logic [CHAR_W-1:0] CH_NL  = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_HY  = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_SP  = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_DOT = 16'h002E;

  typedef enum logic [0:0] {
    CFG_JOIN_LINES  = 1'b0,
    CFG_KEEP_BREAKS = 1'b1
  } lbj_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_FINAL
  } lbj_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic sel_latched;  // decide on the latched item instead of the input
    logic latch_item;   // capture the input beat
    logic do_flush;     // emit one held hyphen
    logic do_final;     // apply the item's own result and state update
  } lbj_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic can_load;     // output register free this cycle
    logic need_flush;   // current item must drain held hyphens first
    logic held_one;     // exactly one hyphen left
  } lbj_status_t;

endpackage

`default_nettype wire

[rtl/lbj_channels.sv]
// Valid/ready stream interfaces for the joiner's input and output beats.
// Depends on lbj_pkg for the character width.
`default_nettype none

interface lbj_in_if import lbj_pkg::*;;
  logic              valid;
  logic              ready;
  logic              command;
  logic [CHAR_W-1:0] in_char;

  modport source (output valid, output command, output in_char, input ready);
  modport sink   (input valid, input command, input in_char, output ready);
endinterface

interface lbj_out_if import lbj_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              end_of_text;
  logic              last;

  modport source (output valid, output out_char, output end_of_text, output last,
                  input ready);
  modport sink   (input valid, input out_char, input end_of_text, input last,
                  output ready);
endinterface

`default_nettype wire

[rtl/lbj_ctrl.sv]
// Sequencing FSM of the line break joiner: accept, hyphen flush, final result.
// Depends on lbj_pkg and the assertion macro header.
`default_nettype none
`include "line_break_joiner_core_macros.svh"

module lbj_ctrl import lbj_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire lbj_status_t status_i,
  output lbj_cmd_t         cmd_o
);

  lbj_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.can_load;
        if (in_valid_i && status_i.can_load) begin
          if (status_i.need_flush) begin
            cmd_o.latch_item = 1'b1;
            state_d          = ST_FLUSH;
          end else begin
            cmd_o.do_final = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        cmd_o.sel_latched = 1'b1;
        if (status_i.can_load) begin
          cmd_o.do_flush = 1'b1;
          if (status_i.held_one) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        cmd_o.sel_latched = 1'b1;
        if (status_i.can_load) begin
          cmd_o.do_final = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `LBJ_ASSERT_IMPL(a_no_accept_busy, state_q != ST_IDLE, !in_ready_o, "ready while busy")
  `LBJ_ASSERT_IMPL(a_one_step, 1'b1, !(cmd_o.do_flush && cmd_o.do_final), "flush and final")
  `LBJ_ASSERT_IMPL(a_step_needs_room, cmd_o.do_flush || cmd_o.do_final, status_i.can_load,
    "step without output room")
  `LBJ_ASSERT_NEXT(a_last_hyphen, state_q == ST_FLUSH && status_i.can_load && status_i.held_one,
    state_q == ST_FINAL, "flush did not end")

endmodule

`default_nettype wire

[rtl/lbj_datapath.sv]
// Datapath of the line break joiner: config, history, hyphen count, output reg.
// Depends on lbj_pkg; driven by lbj_ctrl commands.
`default_nettype none

module lbj_datapath import lbj_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [0:0]        cfg_data_i,
  input  wire logic              in_command_i,
  input  wire logic [CHAR_W-1:0] in_char_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   out_eot_o,
  output logic                   out_last_o,
  input  wire lbj_cmd_t          cmd_i,
  output lbj_status_t            status_o
);

  logic              join_q, keep_q;
  logic [HELD_W-1:0] held_q, held_d;
  logic [CHAR_W-1:0] prev_q, prev_d, pprev_q, pprev_d;
  logic [1:0]        hist_q, hist_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_eot_q, out_eot_d, out_last_q, out_last_d;
  logic              item_cmd_q;
  logic [CHAR_W-1:0] item_char_q;

  logic              cur_cmd;
  logic [CHAR_W-1:0] cur_char;
  logic              is_hy, is_nl, can_load;
  logic              res_emit;
  logic [CHAR_W-1:0] res_char;
  logic [HELD_W-1:0] res_held;
  logic              load;
  logic [CHAR_W-1:0] note_char;
  logic              note;

  assign cur_cmd  = cmd_i.sel_latched ? item_cmd_q  : in_command_i;
  assign cur_char = cmd_i.sel_latched ? item_char_q : in_char_i;
  assign is_hy    = (cur_char == CH_HY);
  assign is_nl    = (cur_char == CH_NL);
  assign can_load = !out_valid_q || out_ready_i;

  assign status_o.can_load   = can_load;
  assign status_o.need_flush = (held_q != '0) && !(join_q && !cur_cmd && (is_hy || is_nl));
  assign status_o.held_one   = (held_q == HELD_W'(1));

  // Own result of a character item once no hyphens wait ahead of it.
  always_comb begin
    res_emit = 1'b1;
    res_char = cur_char;
    res_held = held_q;
    if (join_q && is_hy) begin
      if (held_q < MAX_HELD_HYPHENS) begin
        res_emit = 1'b0;
        res_held = held_q + HELD_W'(1);
      end
    end else if (join_q && is_nl) begin
      res_char = CH_SP;
      if (held_q != '0) begin
        // newline eats a held hyphen
        res_emit = 1'b0;
        res_held = held_q - HELD_W'(1);
      end else if (!keep_q) begin
        if (hist_q != 2'd0 && (prev_q == CH_SP || prev_q == CH_HY)) begin
          res_emit = 1'b0;
        end
      end else if (hist_q == 2'd0) begin
        res_char = CH_NL;
      end else if (prev_q == CH_SP) begin
        if (hist_q == 2'd2 && pprev_q != CH_DOT) begin
          res_emit = 1'b0;
        end else begin
          res_char = CH_NL;
        end
      end else if (prev_q == CH_HY) begin
        res_emit = 1'b0;
      end else if (prev_q == CH_DOT) begin
        res_char = CH_NL;
      end
    end
  end

  always_comb begin
    held_d     = held_q;
    prev_d     = prev_q;
    pprev_d    = pprev_q;
    hist_d     = hist_q;
    load       = 1'b0;
    note       = 1'b0;
    note_char  = res_char;
    out_char_d = out_char_q;
    out_eot_d  = out_eot_q;
    out_last_d = out_last_q;
    if (cmd_i.do_flush) begin
      held_d     = held_q - HELD_W'(1);
      load       = 1'b1;
      note       = 1'b1;
      note_char  = CH_HY;
      out_char_d = CH_HY;
      out_eot_d  = 1'b0;
      out_last_d = 1'b0;
    end else if (cmd_i.do_final) begin
      if (cur_cmd) begin
        load       = 1'b1;
        out_char_d = '0;
        out_eot_d  = 1'b1;
        out_last_d = 1'b1;
      end else begin
        held_d     = res_held;
        load       = res_emit;
        note       = res_emit;
        out_char_d = res_char;
        out_eot_d  = 1'b0;
        out_last_d = 1'b1;
      end
    end
    if (note) begin
      pprev_d = prev_q;
      prev_d  = note_char;
      if (hist_q != 2'd2) begin
        hist_d = hist_q + 2'd1;
      end
    end
    if (cmd_i.do_final && cur_cmd) begin
      held_d  = '0;
      prev_d  = '0;
      pprev_d = '0;
      hist_d  = 2'd0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      join_q      <= 1'b1;
      keep_q      <= 1'b0;
      held_q      <= '0;
      prev_q      <= '0;
      pprev_q     <= '0;
      hist_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_JOIN_LINES:  join_q <= cfg_data_i[0];
          CFG_KEEP_BREAKS: keep_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      held_q      <= held_d;
      prev_q      <= prev_d;
      pprev_q     <= pprev_d;
      hist_q      <= hist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_eot_q  <= out_eot_d;
    out_last_q <= out_last_d;
    if (cmd_i.latch_item) begin
      item_cmd_q  <= in_command_i;
      item_char_q <= in_char_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_eot_o   = out_eot_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

[rtl/line_break_joiner_core.sv]
// Timing: a result beat is valid in the cycle after the input beat is accepted; an
//   item that releases held hyphens is latched in IDLE and shows its first hyphen from FLUSH.
// Throughput: one item per cycle while the output has room and no hyphens must drain;
//   an item that releases k held hyphens walks accept, k flush beats, then its own result.
// The single output register gates acceptance: stalls on the output stall input.
// Reset (rst_ni low, async): join on, keep-breaks off, history and hyphen
//   count cleared, no result pending.
`default_nettype none

module line_break_joiner_core import lbj_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,    // register write strobe
  input  wire logic [0:0] cfg_idx_i,   // 0 join lines, 1 keep sentence breaks
  input  wire logic [0:0] cfg_data_i,
  lbj_in_if.sink          in_i,
  lbj_out_if.source       out_o
);

  lbj_cmd_t    cmd;
  lbj_status_t status;
  logic        in_ready;

  // Controller: IDLE takes a beat when the output register has room; an item
  // that must drain held hyphens is latched and walks FLUSH then FINAL.
  lbj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: config regs, emitted-character history, hyphen counter, and
  // the output beat register.
  lbj_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_command_i (in_i.command),
    .in_char_i    (in_i.in_char),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_char_o   (out_o.out_char),
    .out_eot_o    (out_o.end_of_text),
    .out_last_o   (out_o.last),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

[verif/line_break_joiner_core_tb.sv]
// Self-checking testbench of line_break_joiner_core: directed table, then random text.
// Depends on lbj_pkg and the lbj_in_if / lbj_out_if stream interfaces of the RTL.
`default_nettype none

module line_break_joiner_core_tb import lbj_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Input beat kinds.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOT  = 1'b1;

  localparam int SETTLE_CYCLES = 8;       // result lands in the cycle after accept
  localparam int LONG_STALL    = 300;     // receiver hold-off to back up the input
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 50;
  localparam int DIR_ROWS      = 31;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    lbj_cfg_idx_e      cfg_idx;  // ROW_CFG only, value in ch[0]
    logic              cmd;
    logic [CHAR_W-1:0] ch;
    logic              typed;    // expected beat given below, single beat
    logic [CHAR_W-1:0] exp_ch;
    logic              exp_eot;
  } dir_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eot;
    logic              last;
  } out_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [0:0] cfg_idx;
  logic [0:0] cfg_data;

  lbj_in_if  in_if ();
  lbj_out_if out_if ();

  line_break_joiner_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Joiner predictor: own copy of config and text history.
  // ---------------------------------------------------------------------------
  logic              join_on;
  logic              keep_on;
  logic [HELD_W-1:0] held_cnt;   // hyphens held back, not yet emitted
  logic [CHAR_W-1:0] last_ch;    // last emitted character
  logic [CHAR_W-1:0] last2_ch;   // the one before it
  logic [1:0]        hist;       // emitted characters, saturates at 2

  out_beat_t step_q[$];    // beats caused by the current input beat
  out_beat_t joined_q[$];  // expected output beats, oldest first

  function automatic void emit(logic [CHAR_W-1:0] c, logic eot);
    step_q.push_back('{ch: c, eot: eot, last: 1'b0});
    if (!eot) begin
      last2_ch = last_ch;
      last_ch  = c;
      if (hist < 2'd2) hist++;
    end
  endfunction

  function automatic void flush_held();
    while (held_cnt != '0) begin
      held_cnt--;
      emit(CH_HY, 1'b0);
    end
  endfunction

  function automatic void predict_newline();
    if (held_cnt != '0) begin
      // newline eats the newest held hyphen; the next one cascades
      held_cnt--;
    end else if (!keep_on) begin
      if (hist == 2'd0 || (last_ch != CH_SP && last_ch != CH_HY)) emit(CH_SP, 1'b0);
    end else if (hist == 2'd0) begin
      emit(CH_NL, 1'b0);
    end else if (last_ch == CH_SP) begin
      // kept after ". " or after a lone leading space
      if (hist < 2'd2 || last2_ch == CH_DOT) emit(CH_NL, 1'b0);
    end else if (last_ch == CH_DOT) begin
      emit(CH_NL, 1'b0);
    end else if (last_ch != CH_HY) begin
      // newline becomes a space here; after a hyphen already sent out early it is dropped
      emit(CH_SP, 1'b0);
    end
  endfunction

  function automatic void predict_joined(logic cmd, logic [CHAR_W-1:0] c);
    out_beat_t tail;
    step_q.delete();
    if (cmd == CMD_EOT) begin
      flush_held();
      emit('0, 1'b1);
      held_cnt = '0;
      last_ch  = '0;
      last2_ch = '0;
      hist     = '0;
    end else if (!join_on) begin
      flush_held();
      emit(c, 1'b0);
    end else if (c == CH_HY) begin
      if (held_cnt < MAX_HELD_HYPHENS) held_cnt++;
      else emit(CH_HY, 1'b0);  // counter full: oldest goes out now
    end else if (c == CH_NL) begin
      predict_newline();
    end else begin
      flush_held();
      emit(c, 1'b0);
    end
    if (step_q.size() > 0) begin
      tail      = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left;
  int items_sent;
  int err_cnt;
  int cycle_cnt;
  bit hold_req;   // asks the receiver for its long hold-off
  bit hold_done;

  // Called at a rising edge; returns at the rising edge that accepted the beat.
  task automatic send_item(logic cmd, logic [CHAR_W-1:0] c, logic typed = 1'b0,
                           logic [CHAR_W-1:0] exp_c = '0, logic exp_e = 1'b0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.in_char <= c;
    // inputs only move at rising edges, so the falling edge shows the handshake
    do @(negedge clk_i); while (!in_if.ready);
    predict_joined(cmd, c);
    if (typed) begin
      step_q.delete();
      step_q.push_back('{ch: exp_c, eot: exp_e, last: 1'b1});
    end
    while (step_q.size() > 0) joined_q.push_back(step_q.pop_front());
    items_sent++;
    @(posedge clk_i);
  endtask

  // Register write, only with the block drained.
  task automatic write_reg(lbj_cfg_idx_e idx, logic val);
    in_if.valid <= 1'b0;
    while (joined_q.size() != 0) @(posedge clk_i);
    // a held hyphen causes no beat, so give the core time to settle
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_JOIN_LINES:  join_on = val;
      CFG_KEEP_BREAKS: keep_on = val;
      default: ;
    endcase
  endtask

  // Mostly text-like runs with random content, some noise and bare commands.
  task automatic send_random_text(int n_items, bit with_long_run);
    int start = items_sent;
    int pick;
    int len;
    bit long_done = 1'b0;
    while (items_sent - start < n_items) begin
      if (with_long_run && !long_done && items_sent - start >= n_items / 2) begin
        // overfill the hyphen counter, then outlast it with newlines
        len = $urandom_range(int'(MAX_HELD_HYPHENS) + 1, int'(MAX_HELD_HYPHENS) + 4);
        repeat (len) send_item(CMD_CHAR, CH_HY);
        len = $urandom_range(int'(MAX_HELD_HYPHENS) + 1, int'(MAX_HELD_HYPHENS) + 5);
        repeat (len) send_item(CMD_CHAR, CH_NL);
        long_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          len = $urandom_range(1, 8);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) send_item(CMD_CHAR, 16'($urandom_range(16'h41, 16'h5A)));
            else send_item(CMD_CHAR, 16'($urandom_range(16'h61, 16'h7A)));
          end
        end else if (pick < 50) begin
          send_item(CMD_CHAR, CH_SP);
        end else if (pick < 60) begin
          send_item(CMD_CHAR, CH_DOT);
        end else if (pick < 72) begin
          len = $urandom_range(1, 4);
          repeat (len) send_item(CMD_CHAR, CH_HY);
        end else if (pick < 86) begin
          len = $urandom_range(1, 3);
          repeat (len) send_item(CMD_CHAR, CH_NL);
        end else if (pick < 90) begin
          send_item(CMD_EOT, 16'($urandom_range(0, 16'hFFFF)));
        end else begin
          send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, then random phases over all settings.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    logic j_val;
    logic k_val;

    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.command <= CMD_CHAR;
    in_if.in_char <= '0;
    hold_req   = 1'b0;
    burst_left = 0;
    items_sent = 0;

    // reset state of the predictor matches the core after reset
    join_on  = 1'b1;
    keep_on  = 1'b0;
    held_cnt = '0;
    last_ch  = '0;
    last2_ch = '0;
    hist     = '0;

    dir_rows = '{
      // join on, keep off (reset values)
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b1, CH_SP,    1'b0}, // text start
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, 16'h0061, 1'b1, 16'h0061, 1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_HY,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_HY,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b0, '0,       1'b0}, // cascade
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_SP,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b0, '0,       1'b0}, // after space
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_HY,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, 16'h0000, 1'b0, '0,       1'b0}, // flush first
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_EOT,  16'hFFFF, 1'b1, 16'h0000, 1'b1},
      // keep sentence breaks
      '{ROW_CFG,  CFG_KEEP_BREAKS, CMD_CHAR, 16'h0001, 1'b0, '0, 1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b1, CH_NL,    1'b0}, // text start
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_EOT,  16'h0000, 1'b1, 16'h0000, 1'b1},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_SP,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b0, '0,       1'b0}, // lone space
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_DOT,   1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_SP,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b0, '0,       1'b0}, // after ". "
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, 16'h0062, 1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_SP,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b0, '0,       1'b0}, // dropped
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_HY,    1'b0, '0,       1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_EOT,  16'h0000, 1'b0, '0,       1'b0}, // flush + end
      // join off: pass through
      '{ROW_CFG,  CFG_JOIN_LINES, CMD_CHAR, 16'h0000, 1'b0, '0, 1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_HY,    1'b1, CH_HY,    1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, CH_NL,    1'b1, CH_NL,    1'b0},
      '{ROW_CFG,  CFG_KEEP_BREAKS, CMD_CHAR, 16'h0000, 1'b0, '0, 1'b0},
      '{ROW_ITEM, CFG_JOIN_LINES, CMD_CHAR, 16'h0063, 1'b1, 16'h0063, 1'b0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].ch[0]);
      end else begin
        send_item(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].typed,
                  dir_rows[i].exp_ch, dir_rows[i].exp_eot);
      end
    end

    // first four phases walk every setting, the rest are random
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        j_val = ~p[1];
        k_val = p[0];
      end else begin
        j_val = 1'($urandom_range(0, 1));
        k_val = 1'($urandom_range(0, 1));
      end
      write_reg(CFG_JOIN_LINES, j_val);
      write_reg(CFG_KEEP_BREAKS, k_val);
      if (p == 0) hold_req = 1'b1;
      send_random_text(PHASE_ITEMS, p < 2);
    end

    in_if.valid <= 1'b0;
    while (joined_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern refreshed when the 6-bit phase counter wraps, one long hold-off.
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] rx_pattern;
    logic [5:0] rx_phase;
    rx_pattern = 8'hFF;
    rx_phase   = '0;
    hold_done  = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        // input side keeps offering, so the core fills and stalls it
        out_if.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if (rx_phase == '0) begin
        rx_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      end
      out_if.ready <= rx_pattern[rx_phase[2:0]];
      rx_phase++;
      @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Output check against the oldest expected beat.
  // ---------------------------------------------------------------------------
  initial err_cnt = 0;

  always @(negedge clk_i) begin : check_out
    out_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (joined_q.size() == 0) begin
        $error("unexpected beat: out_char %h end_of_text %b last %b",
               out_if.out_char, out_if.end_of_text, out_if.last);
        err_cnt++;
      end else begin
        want = joined_q.pop_front();
        if (out_if.out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_if.out_char);
          err_cnt++;
        end
        if (out_if.end_of_text !== want.eot) begin
          $error("end_of_text: expected %b, got %b", want.eot, out_if.end_of_text);
          err_cnt++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_if.last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  initial cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

`default_nettype wire
